// ===== rtl/delimiter_pair_deframer_assert.svh =====
// assertion macros shared by the deframer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef DELIMITER_PAIR_DEFRAMER_ASSERT_SVH
`define DELIMITER_PAIR_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dfr_pkg.sv =====
// shared types, constants and helper functions of the delimiter pair deframer
// no dependencies
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int DELIM_MAX  = 8;
  localparam int BYTE_W     = 8;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int MAXLEN_W   = 16;
  localparam int FILL_W     = $clog2(DELIM_MAX + 1);
  localparam int IDX_W      = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int ADDR_W     = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [LEN_W-1:0]    BEGIN_LEN_RST = LEN_W'(1);
  localparam logic [LEN_W-1:0]    END_LEN_RST   = LEN_W'(1);
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RST   = MAXLEN_W'(2048);

  typedef enum logic [ADDR_W-1:0] {
    ADDR_BEGIN_PAT = 6'h00,
    ADDR_BEGIN_LEN = 6'h08,
    ADDR_END_PAT   = 6'h10,
    ADDR_END_LEN   = 6'h18,
    ADDR_MAX_LEN   = 6'h20
  } reg_addr_e;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_BYTE,
    KIND_END,
    KIND_ABORT
  } kind_e;

  typedef logic [DELIM_MAX-1:0][BYTE_W-1:0] win_t;

  typedef struct packed {
    logic [PAT_W-1:0]    begin_pattern;
    logic [LEN_W-1:0]    begin_length;
    logic [PAT_W-1:0]    end_pattern;
    logic [LEN_W-1:0]    end_length;
    logic [MAXLEN_W-1:0] max_frame_length;
  } cfg_t;

  // one queue entry: element 0 of bytes is the newest byte
  typedef struct packed {
    kind_e            kind;
    win_t             bytes;
    logic [IDX_W-1:0] top;
  } cmd_t;

  function automatic logic [FILL_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [FILL_W-1:0] res;
    if (len == '0) begin
      res = FILL_W'(1);
    end else if (int'(len) > DELIM_MAX) begin
      res = FILL_W'(DELIM_MAX);
    end else begin
      res = FILL_W'(len);
    end
    return res;
  endfunction

  function automatic logic win_match(input win_t win, input logic [FILL_W-1:0] fill,
                                     input logic [PAT_W-1:0] pattern,
                                     input logic [FILL_W-1:0] len);
    logic hit;
    hit = (fill >= len);
    for (int i = 0; i < DELIM_MAX; i++) begin
      if ((FILL_W'(i) < len) && (win[i] != pattern[BYTE_W*i +: BYTE_W])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/delimiter_pair_deframer.sv =====
// results pass the command queue and then the output register; throughput: one
// input byte per cycle; a begin match gives begin_length results (clamped to
// 1..8), one per cycle from the back end while m_tready is high, and input
// stalls once the 4-entry queue fills; reset: asynchronous active low;
// registers to defaults, hunting, window empty, queue and output register empty
`timescale 1ns / 1ps

module delimiter_pair_deframer import dfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // data_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,   // out_byte
  output logic [2:0]            m_tuser,   // frame_start, frame_end, frame_abort
  output logic                  m_tlast,   // run_last
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_head;

  assign pready = 1'b1;

  dfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  dfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_tvalid),
    .s_data_i  (s_tdata),
    .s_ready_o (s_tready),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  dfr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_head)
  );

  dfr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_head),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_tvalid),
    .m_ready_i (m_tready),
    .m_data_o  (m_tdata),
    .m_user_o  (m_tuser),
    .m_last_o  (m_tlast)
  );

endmodule

// ===== rtl/dfr_regs.sv =====
// configuration registers behind the apb-style port
// depends on dfr_pkg
`timescale 1ns / 1ps

module dfr_regs import dfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        ADDR_BEGIN_PAT: cfg_d.begin_pattern    = pwdata;
        ADDR_BEGIN_LEN: cfg_d.begin_length     = pwdata[LEN_W-1:0];
        ADDR_END_PAT:   cfg_d.end_pattern      = pwdata;
        ADDR_END_LEN:   cfg_d.end_length       = pwdata[LEN_W-1:0];
        ADDR_MAX_LEN:   cfg_d.max_frame_length = pwdata[MAXLEN_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_BEGIN_PAT: prdata = cfg_q.begin_pattern;
      ADDR_BEGIN_LEN: prdata = CFG_DATA_W'(cfg_q.begin_length);
      ADDR_END_PAT:   prdata = cfg_q.end_pattern;
      ADDR_END_LEN:   prdata = CFG_DATA_W'(cfg_q.end_length);
      ADDR_MAX_LEN:   prdata = CFG_DATA_W'(cfg_q.max_frame_length);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_pattern    <= '0;
      cfg_q.begin_length     <= BEGIN_LEN_RST;
      cfg_q.end_pattern      <= '0;
      cfg_q.end_length       <= END_LEN_RST;
      cfg_q.max_frame_length <= MAX_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dfr_front.sv =====
// front end: takes input bytes, tracks the delimiter window and frame length,
// and queues one command per byte that yields results; depends on dfr_pkg
`timescale 1ns / 1ps

module dfr_front import dfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              s_valid_i,
  input  logic [BYTE_W-1:0] s_data_i,
  output logic              s_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic                collecting_q, collecting_d;
  win_t                win_q, win_d, win_shift;
  logic [FILL_W-1:0]   fill_q, fill_d, fill_inc;
  logic [MAXLEN_W-1:0] count_q, count_d;
  logic [FILL_W-1:0]   bl, el;
  logic                begin_hit, end_hit, acc;

  assign s_ready_o = !full_i;
  assign acc       = s_valid_i && !full_i;

  always_comb begin
    win_shift[0] = s_data_i;
    for (int i = 1; i < DELIM_MAX; i++) begin
      win_shift[i] = win_q[i-1];
    end
  end

  assign fill_inc  = (fill_q == FILL_W'(DELIM_MAX)) ? fill_q : fill_q + 1'b1;
  assign bl        = clamp_len(cfg_i.begin_length);
  assign el        = clamp_len(cfg_i.end_length);
  assign begin_hit = win_match(win_shift, fill_inc, cfg_i.begin_pattern, bl);
  assign end_hit   = win_match(win_shift, fill_inc, cfg_i.end_pattern, el);

  always_comb begin
    collecting_d = collecting_q;
    win_d        = win_q;
    fill_d       = fill_q;
    count_d      = count_q;
    push_o       = 1'b0;
    cmd_o.kind   = KIND_BYTE;
    cmd_o.bytes  = win_shift;
    cmd_o.top    = '0;
    if (acc) begin
      win_d  = win_shift;
      fill_d = fill_inc;
      if (!collecting_q) begin
        if (begin_hit) begin
          push_o       = 1'b1;
          cmd_o.kind   = KIND_BEGIN;
          cmd_o.top    = IDX_W'(bl - 1'b1);
          collecting_d = 1'b1;
          count_d      = MAXLEN_W'(bl);
          win_d        = '0;
          fill_d       = '0;
        end
      end else if (end_hit) begin
        // end delimiter wins over the length limit
        push_o       = 1'b1;
        cmd_o.kind   = KIND_END;
        collecting_d = 1'b0;
        count_d      = '0;
        win_d        = '0;
        fill_d       = '0;
      end else if (count_q >= cfg_i.max_frame_length) begin
        push_o       = 1'b1;
        cmd_o.kind   = KIND_ABORT;
        collecting_d = 1'b0;
        count_d      = '0;
        win_d        = '0;
        fill_d       = '0;
      end else begin
        push_o  = 1'b1;
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      win_q        <= '0;
      fill_q       <= '0;
      count_q      <= '0;
    end else begin
      collecting_q <= collecting_d;
      win_q        <= win_d;
      fill_q       <= fill_d;
      count_q      <= count_d;
    end
  end

endmodule

// ===== rtl/dfr_fifo.sv =====
// short command queue between front and back end
// depends on dfr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "delimiter_pair_deframer_assert.svh"

module dfr_fifo import dfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  `DFR_ASSERT_IMP(a_no_overflow, push_i, !full_o, "command pushed into a full queue")
  `DFR_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "command popped from an empty queue")
  `DFR_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/dfr_back.sv =====
// back end: expands queued commands into result transfers through an output register
// depends on dfr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "delimiter_pair_deframer_assert.svh"

module dfr_back import dfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [BYTE_W-1:0] m_data_o,
  output logic [2:0]        m_user_o,
  output logic              m_last_o
);

  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  idx;
  logic              load, last;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic [2:0]        user_q, user_d;
  logic              last_q;

  assign load = !empty_i && (!valid_q || m_ready_i);
  // begin bursts go oldest byte first
  assign idx  = cmd_i.top - pos_q;
  assign last = (pos_q == cmd_i.top);
  assign pop_o = load && last;

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q && !m_ready_i;
    if (load) begin
      valid_d = 1'b1;
      pos_d   = last ? '0 : pos_q + 1'b1;
    end
    data_d    = (cmd_i.kind == KIND_ABORT) ? '0 : cmd_i.bytes[idx];
    user_d[0] = (cmd_i.kind == KIND_BEGIN) && (pos_q == '0);
    user_d[1] = (cmd_i.kind == KIND_END);
    user_d[2] = (cmd_i.kind == KIND_ABORT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;
  assign m_last_o  = last_q;

  `DFR_ASSERT_IMP(a_abort_zero, m_valid_o && m_user_o[2], m_data_o == '0 && m_last_o, "abort result not zero or not last")
  `DFR_ASSERT_IMP(a_end_last, m_valid_o && m_user_o[1], m_last_o && !m_user_o[0], "end result not last or marked start")
  `DFR_ASSERT_IMP(a_pos_in_burst, !empty_i, pos_q <= cmd_i.top, "burst position beyond command length")

endmodule
